FILE: src/oarr_pkg.sv
// shared constants, types and codes of the rms regulator
package oarr_pkg;

  // fixed block parameters
  localparam int OVERSAMPLE = 7;
  localparam int WINDOW     = 369;
  localparam int ADC_BITS   = 12;

  // field widths
  localparam int SAMPLE_W    = 12;
  localparam int TDATA_IN_W  = 16;
  localparam int OFFSET_W    = 16;
  localparam int VPC_W       = 18;
  localparam int GAIN_W      = 17;
  localparam int COFF_W      = 16;
  localparam int VOLT_W      = 10;
  localparam int DB_W        = 8;
  localparam int ERR_W       = 11;
  localparam int CORR_W      = 2;
  localparam int TDATA_OUT_W = 24;
  localparam int CFG_W       = 18;
  localparam int CFG_IDX_W   = 3;

  // datapath widths
  localparam int GS_W    = $clog2(OVERSAMPLE * ((1 << SAMPLE_W) - 1) + 1);
  localparam int GC_W    = $clog2(OVERSAMPLE + 1);
  localparam int WC_W    = $clog2(WINDOW + 1);
  localparam int SQ_W    = 48;
  localparam int D_W     = OFFSET_W + 1;
  localparam int MAG_W   = OFFSET_W;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int MEAN_W  = PROD_W;
  localparam int R_W     = MEAN_W / 2;
  localparam int VSHIFT  = 20;
  localparam int VINT_W  = R_W + VPC_W - VSHIFT;
  localparam int T_W     = VINT_W + GAIN_W + 2;
  localparam int V_W     = T_W - 1 - 16;
  localparam int ERRX_W  = ERR_W + 1;
  localparam int UW      = R_W + 4;
  localparam int STEP_W  = $clog2(SQ_W + 1);

  // group average as a multiply by the rounded-up reciprocal of OVERSAMPLE,
  // exact for every group sum
  localparam int AVG_SHIFT   = 18;
  localparam int AVG_RECIP_W = 16;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
    AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(OVERSAMPLE) - 64'd1) / 64'(OVERSAMPLE));

  // window mean the same way, in four partial products of PART_W by PART_W bits;
  // the shift keeps the rounding error below one for every reachable square sum
  localparam int MSUM_W    = $clog2(64'(WINDOW) * 64'((1 << MAG_W) - 1) *
                                    64'((1 << MAG_W) - 1) + 64'd1);
  localparam int WIN_SHIFT = 50;
  localparam int PART_W    = 21;
  localparam int MPAIR_W   = 2 * PART_W;
  localparam int ACC_W     = 2 * MPAIR_W;
  localparam logic [63:0] WIN_RECIP_FULL =
    ((64'd1 << WIN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MPAIR_W-1:0] WIN_RECIP = MPAIR_W'(WIN_RECIP_FULL);

  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTS_CODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 3'd7;

  // regulation decision codes
  localparam logic [CORR_W-1:0] CORR_HOLD  = 2'd0;
  localparam logic [CORR_W-1:0] CORR_LOWER = 2'd1;
  localparam logic [CORR_W-1:0] CORR_RAISE = 2'd2;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } oarr_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } oarr_stat_t;

endpackage

FILE: src/oversampled_ac_rms_regulator_top.sv
// true-rms mains voltmeter with deadband raise/lower/hold decision
//
// Raw ADC samples come in one per transfer on the slave stream. Every seven
// samples are averaged (truncating), the Q4 zero-volt offset is removed, the
// difference is squared and summed over a window of 369 averages. At window
// end the block divides the sum by the window length, takes the floor square
// root, scales it to integer volts, applies gain and offset calibration,
// zeroes readings outside [low_limit, high_limit] and sends one result:
// volts, volts minus target and a lower/raise/hold code. tuser high on an
// input restarts both the group and the window with that sample. A sample
// that does not close a group is taken and the block stays ready for the
// next sample. A sample that closes a group keeps the block busy after its
// transfer for a reciprocal multiply for the division by seven, offset
// removal, square and accumulate. A sample that also closes the window
// then adds four partial-product multiply-accumulates for the division by
// the window length, the 16-step square root on the shared compare-subtract
// unit, and scale, calibrate and decide steps. A result waits in an output
// register; only a further result stalls behind it.
// Configuration writes take effect at once and must only happen while idle.
module oversampled_ac_rms_regulator_top import oarr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input samples
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [11:0] sample
  input  logic                   s_axis_tuser,   // [0] sync
  // readings
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [9:0] volts, [20:10] volt_error,
                                                 // [22:21] correction
  output logic                   m_axis_tuser,   // [0] out_of_range
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_SQUARE,
    ST_SQ_MUL,
    ST_ACCUM,
    ST_MEAN_MUL,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_SCALE,
    ST_CAL,
    ST_DECIDE
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [OFFSET_W-1:0]      offset_q;
  logic [VPC_W-1:0]         vpc_q;
  logic [GAIN_W-1:0]        gain_q;
  logic signed [COFF_W-1:0] coff_q;
  logic [VOLT_W-1:0]        target_q;
  logic [DB_W-1:0]          deadband_q;
  logic [VOLT_W-1:0]        low_q;
  logic [VOLT_W-1:0]        high_q;

  // accumulation state
  logic [GS_W-1:0] group_sum_q, group_sum_d;
  logic [GC_W-1:0] group_count_q, group_count_d;
  logic [WC_W-1:0] window_count_q, window_count_d;
  logic [SQ_W-1:0] square_sum_q, square_sum_d;

  // datapath registers
  logic [SAMPLE_W-1:0] avg_q, avg_d;
  logic [MAG_W-1:0]    dmag_q, dmag_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [1:0]          mstep_q, mstep_d;
  logic [ACC_W-1:0]    macc_q, macc_d;
  logic [MEAN_W-1:0]   mean_q, mean_d;
  logic [R_W-1:0]      root_q, root_d;
  logic [VINT_W-1:0]   vint_q, vint_d;
  logic signed [T_W-1:0] t_q, t_d;

  // output register
  logic                     m_valid_q, m_valid_d;
  logic [VOLT_W-1:0]        volts_q, volts_d;
  logic                     oor_q, oor_d;
  logic [ERR_W-1:0]         err_q, err_d;
  logic [CORR_W-1:0]        corr_q, corr_d;

  // shared unit
  oarr_cmd_t        cmd;
  oarr_stat_t       stat;
  logic [SQ_W-1:0]  unit_operand, unit_result;

  // combinational datapath pieces
  logic                        in_xfer;
  logic [SAMPLE_W-1:0]         sample_m;
  logic [GS_W+AVG_RECIP_W-1:0] avg_prod;
  logic [MPAIR_W-1:0]          msum_ext;
  logic [PART_W-1:0]           mul_a, mul_b;
  logic [MPAIR_W-1:0]          mul_p;
  logic [ACC_W-1:0]            mul_term;
  logic signed [D_W-1:0]       d_val, d_neg;
  logic [R_W+VPC_W-1:0]        scale_prod;
  logic [VINT_W+GAIN_W-1:0]    cal_prod;
  logic signed [T_W-1:0]       coff_ext;
  logic [V_W-1:0]              v_val;
  logic                        out_rng;
  logic [VOLT_W-1:0]           volts_val;
  logic signed [ERRX_W-1:0]    err_val, db_pos, db_neg;
  logic                        slot_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign sample_m      = s_axis_tdata[SAMPLE_W-1:0] & ADC_MASK;
  assign slot_free     = !m_valid_q || m_axis_tready;

  // group average: multiply by the reciprocal of the group length
  assign avg_prod = group_sum_q * AVG_RECIP;

  // window mean: one partial product of square sum and reciprocal per step,
  // low halves first
  assign msum_ext = MPAIR_W'(square_sum_q[MSUM_W-1:0]);
  assign mul_a    = mstep_q[1] ? msum_ext[MPAIR_W-1:PART_W] : msum_ext[PART_W-1:0];
  assign mul_b    = mstep_q[0] ? WIN_RECIP[MPAIR_W-1:PART_W] : WIN_RECIP[PART_W-1:0];
  assign mul_p    = mul_a * mul_b;

  always_comb begin
    case (mstep_q)
      2'd0:    mul_term = ACC_W'(mul_p);
      2'd3:    mul_term = ACC_W'(mul_p) << MPAIR_W;
      default: mul_term = ACC_W'(mul_p) << PART_W;
    endcase
  end

  // offset removal and magnitude of the Q4 difference
  assign d_val = $signed({1'b0, avg_q, 4'b0000}) - $signed({1'b0, offset_q});
  assign d_neg = -d_val;

  // scaling to volts and calibration
  assign scale_prod = root_q * vpc_q;
  assign cal_prod   = vint_q * gain_q;
  assign coff_ext   = {{(T_W-COFF_W-8){coff_q[COFF_W-1]}}, coff_q, 8'b0};

  // range check and deadband decision
  assign v_val     = t_q[T_W-2:16];
  assign out_rng   = t_q[T_W-1] || (v_val < V_W'(low_q)) || (v_val > V_W'(high_q));
  assign volts_val = out_rng ? '0 : v_val[VOLT_W-1:0];
  assign err_val   = $signed({2'b00, volts_val}) - $signed({2'b00, target_q});
  assign db_pos    = $signed({{(ERRX_W-DB_W){1'b0}}, deadband_q});
  assign db_neg    = -db_pos;

  always_comb begin
    state_d        = state_q;
    group_sum_d    = group_sum_q;
    group_count_d  = group_count_q;
    window_count_d = window_count_q;
    square_sum_d   = square_sum_q;
    avg_d          = avg_q;
    dmag_d         = dmag_q;
    prod_d         = prod_q;
    mstep_d        = mstep_q;
    macc_d         = macc_q;
    mean_d         = mean_q;
    root_d         = root_q;
    vint_d         = vint_q;
    t_d            = t_q;
    m_valid_d      = m_valid_q && !m_axis_tready;
    volts_d        = volts_q;
    oor_d          = oor_q;
    err_d          = err_q;
    corr_d         = corr_q;
    cmd.start      = 1'b0;
    cmd.steps      = STEP_W'(R_W);
    unit_operand   = SQ_W'(mean_q) << (SQ_W - MEAN_W);

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          // sync restarts group and window with this sample
          if (s_axis_tuser) begin
            group_sum_d    = GS_W'(sample_m);
            group_count_d  = GC_W'(1);
            window_count_d = '0;
            square_sum_d   = '0;
          end else begin
            group_sum_d   = group_sum_q + GS_W'(sample_m);
            group_count_d = group_count_q + 1'b1;
          end
          if (group_count_d == GC_W'(OVERSAMPLE)) begin
            state_d = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        avg_d         = avg_prod[AVG_SHIFT +: SAMPLE_W];
        group_sum_d   = '0;
        group_count_d = '0;
        state_d       = ST_SQUARE;
      end
      ST_SQUARE: begin
        dmag_d  = d_val[D_W-1] ? d_neg[MAG_W-1:0] : d_val[MAG_W-1:0];
        state_d = ST_SQ_MUL;
      end
      ST_SQ_MUL: begin
        prod_d  = dmag_q * dmag_q;
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        square_sum_d   = square_sum_q + SQ_W'(prod_q);
        window_count_d = window_count_q + 1'b1;
        mstep_d        = '0;
        macc_d         = '0;
        state_d        = (window_count_d == WC_W'(WINDOW)) ? ST_MEAN_MUL : ST_IDLE;
      end
      ST_MEAN_MUL: begin
        macc_d  = macc_q + mul_term;
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd3) begin
          mean_d         = macc_d[WIN_SHIFT +: MEAN_W];
          square_sum_d   = '0;
          window_count_d = '0;
          state_d        = ST_ROOT_GO;
        end
      end
      ST_ROOT_GO: begin
        cmd.start = 1'b1;
        state_d   = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (stat.done) begin
          root_d  = unit_result[R_W-1:0];
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        vint_d  = scale_prod[R_W+VPC_W-1:VSHIFT];
        state_d = ST_CAL;
      end
      ST_CAL: begin
        t_d     = $signed(T_W'(cal_prod)) - coff_ext;
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // wait for the output register to be free
        if (slot_free) begin
          m_valid_d = 1'b1;
          volts_d   = volts_val;
          oor_d     = out_rng;
          err_d     = err_val[ERR_W-1:0];
          if (err_val >= db_pos) begin
            corr_d = CORR_LOWER;
          end else if (err_val <= db_neg) begin
            corr_d = CORR_RAISE;
          end else begin
            corr_d = CORR_HOLD;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      offset_q       <= OFFSET_W'(41298);
      vpc_q          <= VPC_W'(23768);
      gain_q         <= GAIN_W'(64599);
      coff_q         <= COFF_W'(4780);
      target_q       <= VOLT_W'(230);
      deadband_q     <= DB_W'(4);
      low_q          <= VOLT_W'(100);
      high_q         <= VOLT_W'(1000);
      group_sum_q    <= '0;
      group_count_q  <= '0;
      window_count_q <= '0;
      square_sum_q   <= '0;
      avg_q          <= '0;
      dmag_q         <= '0;
      prod_q         <= '0;
      mstep_q        <= '0;
      macc_q         <= '0;
      mean_q         <= '0;
      root_q         <= '0;
      vint_q         <= '0;
      t_q            <= '0;
      m_valid_q      <= 1'b0;
      volts_q        <= '0;
      oor_q          <= 1'b0;
      err_q          <= '0;
      corr_q         <= CORR_HOLD;
    end else begin
      state_q        <= state_d;
      group_sum_q    <= group_sum_d;
      group_count_q  <= group_count_d;
      window_count_q <= window_count_d;
      square_sum_q   <= square_sum_d;
      avg_q          <= avg_d;
      dmag_q         <= dmag_d;
      prod_q         <= prod_d;
      mstep_q        <= mstep_d;
      macc_q         <= macc_d;
      mean_q         <= mean_d;
      root_q         <= root_d;
      vint_q         <= vint_d;
      t_q            <= t_d;
      m_valid_q      <= m_valid_d;
      volts_q        <= volts_d;
      oor_q          <= oor_d;
      err_q          <= err_d;
      corr_q         <= corr_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_OFFSET_CODE: offset_q   <= cfg_data_i[OFFSET_W-1:0];
          REG_VOLTS_CODE:  vpc_q      <= cfg_data_i[VPC_W-1:0];
          REG_CORR_GAIN:   gain_q     <= cfg_data_i[GAIN_W-1:0];
          REG_CORR_OFFSET: coff_q     <= cfg_data_i[COFF_W-1:0];
          REG_TARGET:      target_q   <= cfg_data_i[VOLT_W-1:0];
          REG_DEADBAND:    deadband_q <= cfg_data_i[DB_W-1:0];
          REG_LOW_LIMIT:   low_q      <= cfg_data_i[VOLT_W-1:0];
          REG_HIGH_LIMIT:  high_q     <= cfg_data_i[VOLT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  oarr_iter_unit u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .operand_i (unit_operand),
    .stat_o    (stat),
    .result_o  (unit_result)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(TDATA_OUT_W-VOLT_W-ERR_W-CORR_W){1'b0}}, corr_q, err_q, volts_q};
  assign m_axis_tuser  = oor_q;

  // the shared unit is never restarted while it still iterates
  a_unit_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !stat.busy)
    else $error("shared unit started while busy");

  // counters wrap before the block is ready for the next sample
  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (group_count_q < GC_W'(OVERSAMPLE)) &&
                             (window_count_q < WC_W'(WINDOW)))
    else $error("group or window count out of range while idle");

  // a zeroed reading carries zero volts
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && oor_q) |-> (volts_q == '0))
    else $error("out of range reading with nonzero volts");

endmodule

FILE: src/oarr_iter_unit.sv
// shared compare-subtract unit: integer square root, one result bit a cycle
module oarr_iter_unit import oarr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oarr_cmd_t        cmd_i,
  input  logic [SQ_W-1:0]  operand_i,   // left aligned
  output oarr_stat_t       stat_o,
  output logic [SQ_W-1:0]  result_o
);

  logic [SQ_W-1:0]   opnd_q, opnd_d;
  logic [UW-1:0]     rem_q, rem_d;
  logic [SQ_W-1:0]   quo_q, quo_d;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;

  logic [UW-1:0]     shifted, trial;
  logic [UW:0]       diff;
  logic              ge;

  always_comb begin
    shifted = {rem_q[UW-3:0], opnd_q[SQ_W-1 -: 2]};
    trial   = {quo_q[UW-3:0], 2'b01};
    opnd_d  = opnd_q << 2;
    diff    = {1'b0, shifted} - {1'b0, trial};
    ge      = ~diff[UW];
    rem_d   = ge ? diff[UW-1:0] : shifted;
    quo_d   = {quo_q[SQ_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      opnd_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
        opnd_q <= operand_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        opnd_q <= opnd_d;
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = quo_q;

endmodule
